/* rtl/core/x86_16_register_alu_step_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the register ALU step block
// Shared helpers for concurrent checks clocked on the rising edge.
// ----------------------------------------------------------------------------
`ifndef X86_16_REGISTER_ALU_STEP_DEFINES_SVH
`define X86_16_REGISTER_ALU_STEP_DEFINES_SVH

// Property that holds at every edge while reset is released.
`define X86RS_ASSERT(lbl, ck, rstn, prop, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) (prop)) else $error(msg);

// Condition that must never be true while reset is released.
`define X86RS_NEVER(lbl, ck, rstn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* rtl/core/x86rs_pkg.sv */
// ----------------------------------------------------------------------------
// x86rs_pkg
// Types, constants and operand helpers for the register ALU step block.
// ----------------------------------------------------------------------------
package x86rs_pkg;

	localparam int SLOT_COUNT = 12;
	localparam int SLOT_W     = 4;
	localparam int WORD_W     = 16;

	localparam int ZF_BIT = 6;
	localparam int PF_BIT = 2;
	localparam int SF_BIT = 7;

	localparam logic [SLOT_W-1:0] IP_SLOT  = 4'd12;
	localparam logic [SLOT_W-1:0] SEG_BASE = 4'd8;

	localparam logic [1:0] KIND_GENERAL = 2'd0;
	localparam logic [1:0] KIND_SEGMENT = 2'd1;

	typedef enum logic [2:0] {
		CMD_MOV = 3'd0,
		CMD_ADD = 3'd1,
		CMD_SUB = 3'd2,
		CMD_CMP = 3'd3,
		CMD_JNZ = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		PART_WIDE = 2'd0,
		PART_LOW  = 2'd1,
		PART_HIGH = 2'd2
	} part_t;

	typedef struct packed {
		logic [SLOT_W-1:0] slot;
		part_t             part;
	} operand_t;

	// Decoded instruction as it travels into the execute stage.
	typedef struct packed {
		cmd_t              cmd;
		logic [SLOT_W-1:0] dslot;
		part_t             dpart;
		logic              src_imm;
		part_t             spart;
		logic [WORD_W-1:0] imm;
		logic [WORD_W-1:0] tgt;
	} op_t;

	// Outcome of the execute stage.
	typedef struct packed {
		logic [SLOT_W-1:0] dest_slot;
		logic [WORD_W-1:0] dest_before;
		logic [WORD_W-1:0] dest_after;
		logic [WORD_W-1:0] ip_after;
		logic [WORD_W-1:0] flags_after;
		logic              written;
	} res_t;

	function automatic operand_t decode_operand(logic is_seg, logic [2:0] field, logic w);
		operand_t o;
		if (is_seg) begin
			o.slot = SEG_BASE | {2'b00, field[1:0]};
			o.part = PART_WIDE;
		end else if (w) begin
			o.slot = {1'b0, field};
			o.part = PART_WIDE;
		end else begin
			o.slot = {2'b00, field[1:0]};
			o.part = field[2] ? PART_HIGH : PART_LOW;
		end
		return o;
	endfunction

	function automatic logic [WORD_W-1:0] part_get(logic [WORD_W-1:0] full, part_t part);
		logic [WORD_W-1:0] v;
		unique case (part)
			PART_LOW:  v = {8'h00, full[7:0]};
			PART_HIGH: v = {8'h00, full[15:8]};
			default:   v = full;
		endcase
		return v;
	endfunction

	function automatic logic [WORD_W-1:0] part_put(logic [WORD_W-1:0] full,
			logic [WORD_W-1:0] v, part_t part);
		logic [WORD_W-1:0] r;
		unique case (part)
			PART_LOW:  r = {full[15:8], v[7:0]};
			PART_HIGH: r = {v[7:0], full[7:0]};
			default:   r = v;
		endcase
		return r;
	endfunction

endpackage

/* rtl/core/x86_16_register_alu_step.sv */
// An accepted transaction is registered with its register file reads, then in the
// output registers on the result ports; one instruction per cycle while not stalled.
// Register reads and the execute stage overlap; a write in flight is forwarded.
// Reset clears the register file valid bits, IP, flags and all valid flags at once;
// no clearing pass is needed and the block accepts right after reset.
// ----------------------------------------------------------------------------
// x86_16_register_alu_step
// Top level: decode, register file read, execute and output register.
// ----------------------------------------------------------------------------
module x86_16_register_alu_step (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  command,
	input  logic        wide,
	input  logic        dest_kind,
	input  logic [2:0]  dest_field,
	input  logic [1:0]  source_kind,
	input  logic [2:0]  source_field,
	input  logic [15:0] immediate_value,
	input  logic [15:0] jump_target,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  dest_slot,
	output logic [15:0] dest_before,
	output logic [15:0] dest_after,
	output logic [15:0] ip_before,
	output logic [15:0] ip_after,
	output logic [15:0] flags_before,
	output logic [15:0] flags_after,
	output logic        register_written
);
	import x86rs_pkg::*;

	operand_t          d_dec;
	operand_t          s_dec;
	op_t               op_in;
	op_t               op_s1;
	logic              valid_s1;
	logic              fwd_d_s1;
	logic              fwd_s_s1;
	logic [WORD_W-1:0] fwd_data_s1;
	logic [WORD_W-1:0] rd_d;
	logic [WORD_W-1:0] rd_s;
	logic [WORD_W-1:0] dfull;
	logic [WORD_W-1:0] sfull;
	logic [WORD_W-1:0] ip_q;
	logic [WORD_W-1:0] flags_q;
	res_t              res;
	logic              accept;
	logic              s1_adv;
	logic              s1_fire;
	logic              wr_en;

	logic              out_valid_q;
	logic [SLOT_W-1:0] dest_slot_q;
	logic [WORD_W-1:0] dest_before_q;
	logic [WORD_W-1:0] dest_after_q;
	logic [WORD_W-1:0] ip_before_q;
	logic [WORD_W-1:0] ip_after_q;
	logic [WORD_W-1:0] flags_before_q;
	logic [WORD_W-1:0] flags_after_q;
	logic              written_q;

	assign d_dec = decode_operand(dest_kind, dest_field, wide);
	assign s_dec = decode_operand(source_kind == KIND_SEGMENT, source_field, wide);

	always_comb begin
		op_in.cmd     = cmd_t'(command);
		op_in.dslot   = d_dec.slot;
		op_in.dpart   = d_dec.part;
		op_in.src_imm = source_kind[1];
		op_in.spart   = s_dec.part;
		op_in.imm     = immediate_value;
		op_in.tgt     = jump_target;
	end

	assign s1_adv   = !out_valid_q || !out_stall;
	assign s1_fire  = valid_s1 && s1_adv;
	assign in_stall = valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;
	assign wr_en    = s1_fire && res.written;

	x86rs_regfile u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (accept),
		.rd_addr_a (d_dec.slot),
		.rd_addr_b (s_dec.slot),
		.rd_data_a (rd_d),
		.rd_data_b (rd_s),
		.wr_en     (wr_en),
		.wr_addr   (op_s1.dslot),
		.wr_data   (res.dest_after)
	);

	// A write retiring at the edge that reads the same slot is captured here,
	// since the memory returns the old contents in that case.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1       <= op_in;
			fwd_d_s1    <= wr_en && (op_s1.dslot == d_dec.slot);
			fwd_s_s1    <= wr_en && (op_s1.dslot == s_dec.slot);
			fwd_data_s1 <= res.dest_after;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			valid_s1 <= 1'b0;
		end
	end

	assign dfull = fwd_d_s1 ? fwd_data_s1 : rd_d;
	assign sfull = fwd_s_s1 ? fwd_data_s1 : rd_s;

	x86rs_alu u_alu (
		.op    (op_s1),
		.dfull (dfull),
		.sfull (sfull),
		.ip    (ip_q),
		.flags (flags_q),
		.res   (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ip_q    <= '0;
			flags_q <= '0;
		end else if (s1_fire) begin
			ip_q    <= res.ip_after;
			flags_q <= res.flags_after;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			dest_slot_q    <= res.dest_slot;
			dest_before_q  <= res.dest_before;
			dest_after_q   <= res.dest_after;
			ip_before_q    <= ip_q;
			ip_after_q     <= res.ip_after;
			flags_before_q <= flags_q;
			flags_after_q  <= res.flags_after;
			written_q      <= res.written;
		end
	end

	assign out_valid        = out_valid_q;
	assign dest_slot        = dest_slot_q;
	assign dest_before      = dest_before_q;
	assign dest_after       = dest_after_q;
	assign ip_before        = ip_before_q;
	assign ip_after         = ip_after_q;
	assign flags_before     = flags_before_q;
	assign flags_after      = flags_after_q;
	assign register_written = written_q;

endmodule

/* rtl/core/x86rs_regfile.sv */
// ----------------------------------------------------------------------------
// x86rs_regfile
// General and segment register storage: one write port, two registered reads.
// ----------------------------------------------------------------------------
module x86rs_regfile (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [x86rs_pkg::SLOT_W-1:0]  rd_addr_a,
	input  logic [x86rs_pkg::SLOT_W-1:0]  rd_addr_b,
	output logic [x86rs_pkg::WORD_W-1:0]  rd_data_a,
	output logic [x86rs_pkg::WORD_W-1:0]  rd_data_b,
	input  logic                          wr_en,
	input  logic [x86rs_pkg::SLOT_W-1:0]  wr_addr,
	input  logic [x86rs_pkg::WORD_W-1:0]  wr_data
);
	import x86rs_pkg::*;

	logic [WORD_W-1:0] mem_q [SLOT_COUNT];
	logic [SLOT_COUNT-1:0] valid_q;
	logic [WORD_W-1:0] rd_data_a_q;
	logic [WORD_W-1:0] rd_data_b_q;

	// Entries that were never written since reset read as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_a_q <= valid_q[rd_addr_a] ? mem_q[rd_addr_a] : '0;
			rd_data_b_q <= valid_q[rd_addr_b] ? mem_q[rd_addr_b] : '0;
		end
	end

	assign rd_data_a = rd_data_a_q;
	assign rd_data_b = rd_data_b_q;

endmodule

/* rtl/core/x86rs_alu.sv */
// ----------------------------------------------------------------------------
// x86rs_alu
// Execute stage: operand selection, move, add, subtract and compare, flag update, branch.
// ----------------------------------------------------------------------------
module x86rs_alu (
	input  x86rs_pkg::op_t                op,
	input  logic [x86rs_pkg::WORD_W-1:0]  dfull,
	input  logic [x86rs_pkg::WORD_W-1:0]  sfull,
	input  logic [x86rs_pkg::WORD_W-1:0]  ip,
	input  logic [x86rs_pkg::WORD_W-1:0]  flags,
	output x86rs_pkg::res_t               res
);
	import x86rs_pkg::*;

	logic [WORD_W-1:0] dval;
	logic [WORD_W-1:0] sval;
	logic [WORD_W-1:0] wmask;
	logic [WORD_W-1:0] sum;
	logic [WORD_W-1:0] diff;
	logic [WORD_W-1:0] value;
	logic [WORD_W-1:0] arith_flags;
	logic [WORD_W-1:0] new_flags;
	logic [WORD_W-1:0] new_ip;
	logic              write;
	logic              arith;

	assign dval  = part_get(dfull, op.dpart);
	assign sval  = op.src_imm ? op.imm : part_get(sfull, op.spart);
	assign wmask = (op.dpart == PART_WIDE) ? 16'hFFFF : 16'h00FF;
	assign sum   = (dval + sval) & wmask;
	assign diff  = (dval - sval) & wmask;

	always_comb begin
		value  = dfull;
		write  = 1'b0;
		arith  = 1'b0;
		new_ip = ip;
		unique case (op.cmd)
			CMD_MOV: begin
				value = sval & wmask;
				write = 1'b1;
			end
			CMD_ADD: begin
				value = sum;
				write = 1'b1;
				arith = 1'b1;
			end
			CMD_SUB: begin
				value = diff;
				write = 1'b1;
				arith = 1'b1;
			end
			CMD_CMP: begin
				value = diff;
				arith = 1'b1;
			end
			CMD_JNZ: begin
				new_ip = flags[ZF_BIT] ? ip : op.tgt;
			end
			default: begin
				value = dfull;
			end
		endcase
	end

	// Parity looks at the low byte only; sign comes from the operation width.
	always_comb begin
		arith_flags         = flags;
		arith_flags[ZF_BIT] = (value == '0);
		arith_flags[PF_BIT] = ~^value[7:0];
		arith_flags[SF_BIT] = (op.dpart == PART_WIDE) ? value[15] : value[7];
		new_flags           = arith ? arith_flags : flags;
	end

	always_comb begin
		if (op.cmd == CMD_JNZ) begin
			res.dest_slot   = IP_SLOT;
			res.dest_before = ip;
			res.dest_after  = new_ip;
		end else begin
			res.dest_slot   = op.dslot;
			res.dest_before = dfull;
			res.dest_after  = write ? part_put(dfull, value, op.dpart) : dfull;
		end
		res.ip_after    = new_ip;
		res.flags_after = new_flags;
		res.written     = write;
	end

endmodule

/* rtl/core/x86rs_checker.sv */
// ----------------------------------------------------------------------------
// x86rs_checker
// Port-level checks on result transactions of the register ALU step block.
// ----------------------------------------------------------------------------
`include "x86_16_register_alu_step_defines.svh"

module x86rs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        out_valid,
	input logic        out_stall,
	input logic [3:0]  dest_slot,
	input logic [15:0] dest_before,
	input logic [15:0] dest_after,
	input logic [15:0] ip_before,
	input logic [15:0] ip_after,
	input logic        register_written
);
	import x86rs_pkg::*;

	`X86RS_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "result dropped while stalled")
	`X86RS_NEVER(a_jnz_no_write, clk, arst_n, out_valid && dest_slot == IP_SLOT && register_written, "branch reported a register write")
	`X86RS_ASSERT(a_jnz_ip, clk, arst_n, out_valid && dest_slot == IP_SLOT |-> dest_before == ip_before && dest_after == ip_after, "branch destination differs from IP")
	`X86RS_ASSERT(a_no_write_same, clk, arst_n, out_valid && !register_written && dest_slot != IP_SLOT |-> dest_before == dest_after, "destination changed without a write")
	`X86RS_ASSERT(a_ip_only_branch, clk, arst_n, out_valid && ip_before != ip_after |-> dest_slot == IP_SLOT, "IP changed by a non-branch")

endmodule

bind x86_16_register_alu_step x86rs_checker u_checker (.*);
